FILE: rtl/cantr_pkg.sv
`timescale 1ns / 1ps

package cantr_pkg;

	// Input item kinds
	localparam logic [1:0] OP_SINGLE = 2'd0;
	localparam logic [1:0] OP_FIRST  = 2'd1;
	localparam logic [1:0] OP_CONSEC = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_CTS     = 2'd1;
	localparam logic [1:0] KIND_ABORT   = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	// Receive phases
	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_PROGRESS = 2'd1;
	localparam logic [1:0] PH_BROKEN   = 2'd2;

	// Configuration register indexes
	localparam logic REG_BLOCK_SIZE    = 1'b0;
	localparam logic REG_TIMEOUT_TICKS = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam int          FRAME_BYTES   = 7;
	localparam int          RQ_DEPTH      = 4;
	localparam int          RQ_PTR_W      = $clog2(RQ_DEPTH);

	typedef struct packed {
		logic [11:0]                  total_length;
		logic [3:0]                   seq_index;
		logic [2:0]                   byte_count;
		logic [FRAME_BYTES-1:0][7:0] data;
		logic [1:0]                   op;
	} item_t;

	typedef struct packed {
		logic                         last;
		logic [7:0]                   fc_block_size;
		logic                         message_end;
		logic [2:0]                   out_count;
		logic [FRAME_BYTES-1:0][7:0] data;
		logic [1:0]                   kind;
	} result_t;

	// Up to two results come out of one item, in order first then second
	typedef struct packed {
		result_t    first;
		result_t    second;
		logic [1:0] count;
	} step_t;

	typedef struct packed {
		logic        en;
		logic        index;
		logic [15:0] data;
	} cfg_wr_t;

	function automatic result_t make_payload(input item_t it, input logic [2:0] cnt,
			input logic end_flag);
		result_t r;
		r = '0;
		r.kind = KIND_PAYLOAD;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			r.data[i] = (3'(i) < cnt) ? it.data[i] : 8'd0;
		end
		r.out_count = cnt;
		r.message_end = end_flag;
		return r;
	endfunction

	function automatic result_t make_fc(input logic [1:0] k, input logic [7:0] bs);
		result_t r;
		r = '0;
		r.kind = k;
		r.fc_block_size = bs;
		return r;
	endfunction

endpackage

FILE: rtl/cantr_engine.sv
`timescale 1ns / 1ps

module cantr_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  cantr_pkg::cfg_wr_t cfg,
	input  logic             go,
	input  cantr_pkg::item_t item,
	output cantr_pkg::step_t step
);
	import cantr_pkg::*;

	logic [7:0]  block_size_q;
	logic [15:0] timeout_q;

	logic [1:0]  phase_q, phase_d;
	logic [11:0] exp_len_q, exp_len_d;
	logic [11:0] rcv_q, rcv_d;
	logic [3:0]  seq_q, seq_d;
	logic [7:0]  fib_q, fib_d;
	logic        tmr_run_q, tmr_run_d;
	logic [15:0] tmr_rem_q, tmr_rem_d;

	logic [2:0]  take_ff, take_cf;
	logic [11:0] rem_len, rcv_sum;
	logic [3:0]  seq_inc;
	logic [7:0]  fib_inc;
	step_t       st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= 8'd0;
			timeout_q    <= TIMEOUT_RESET;
		end else if (cfg.en) begin
			if (cfg.index == REG_BLOCK_SIZE) begin
				block_size_q <= cfg.data[7:0];
			end else begin
				timeout_q <= cfg.data;
			end
		end
	end

	assign take_ff = ({9'd0, item.byte_count} < item.total_length) ?
		item.byte_count : item.total_length[2:0];
	assign rem_len = exp_len_q - rcv_q;
	assign take_cf = ({9'd0, item.byte_count} < rem_len) ? item.byte_count : rem_len[2:0];
	assign rcv_sum = rcv_q + {9'd0, take_cf};
	assign seq_inc = seq_q + 4'd1;
	assign fib_inc = fib_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		exp_len_d = exp_len_q;
		rcv_d     = rcv_q;
		seq_d     = seq_q;
		fib_d     = fib_q;
		tmr_run_d = tmr_run_q;
		tmr_rem_d = tmr_rem_q;
		st        = '0;
		case (item.op)
			OP_SINGLE: begin
				st.first  = make_payload(item, item.byte_count, 1'b1);
				st.count  = 2'd1;
				tmr_run_d = 1'b1;
				tmr_rem_d = timeout_q;
			end
			OP_FIRST: begin
				if (phase_q == PH_PROGRESS) begin
					// A new first frame breaks the running message; the timer keeps going.
					phase_d  = PH_BROKEN;
					st.first = make_fc(KIND_ABORT, 8'd0);
					st.count = 2'd1;
				end else begin
					exp_len_d = item.total_length;
					rcv_d     = {9'd0, take_ff};
					seq_d     = 4'd0;
					fib_d     = 8'd0;
					if ({9'd0, take_ff} >= item.total_length) begin
						phase_d   = PH_IDLE;
						st.first  = make_payload(item, take_ff, 1'b1);
						st.count  = 2'd1;
						tmr_run_d = 1'b0;
						tmr_rem_d = 16'd0;
					end else begin
						phase_d   = PH_PROGRESS;
						st.first  = make_payload(item, take_ff, 1'b0);
						st.second = make_fc(KIND_CTS, block_size_q);
						st.count  = 2'd2;
						tmr_run_d = 1'b1;
						tmr_rem_d = timeout_q;
					end
				end
			end
			OP_CONSEC: begin
				if (phase_q == PH_PROGRESS) begin
					seq_d     = seq_inc;
					tmr_run_d = 1'b0;
					tmr_rem_d = 16'd0;
					if (seq_inc == item.seq_index) begin
						rcv_d    = rcv_sum;
						fib_d    = fib_inc;
						st.first = make_payload(item, take_cf, rcv_sum == exp_len_q);
						st.count = 2'd1;
						if (rcv_sum == exp_len_q) begin
							phase_d = PH_IDLE;
						end else begin
							tmr_run_d = 1'b1;
							tmr_rem_d = timeout_q;
							if (block_size_q != 8'd0 && fib_inc == block_size_q) begin
								fib_d     = 8'd0;
								st.second = make_fc(KIND_CTS, block_size_q);
								st.count  = 2'd2;
							end
						end
					end else begin
						phase_d  = PH_BROKEN;
						st.first = make_fc(KIND_ABORT, 8'd0);
						st.count = 2'd1;
					end
				end else if (phase_q == PH_IDLE) begin
					phase_d  = PH_BROKEN;
					st.first = make_fc(KIND_ABORT, 8'd0);
					st.count = 2'd1;
				end
			end
			default: begin
				// Tick: a zero load expires on the first tick, the same as one.
				if (tmr_run_q) begin
					if (tmr_rem_q <= 16'd1) begin
						tmr_run_d = 1'b0;
						tmr_rem_d = 16'd0;
						st.first  = make_fc(KIND_ABORT, 8'd0);
						st.second = make_fc(KIND_TIMEOUT, 8'd0);
						st.count  = 2'd2;
					end else begin
						tmr_rem_d = tmr_rem_q - 16'd1;
					end
				end
			end
		endcase
		st.first.last  = (st.count == 2'd1);
		st.second.last = (st.count == 2'd2);
	end

	assign step = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			exp_len_q <= 12'd0;
			rcv_q     <= 12'd0;
			seq_q     <= 4'd0;
			fib_q     <= 8'd0;
			tmr_run_q <= 1'b0;
			tmr_rem_q <= 16'd0;
		end else if (go) begin
			phase_q   <= phase_d;
			exp_len_q <= exp_len_d;
			rcv_q     <= rcv_d;
			seq_q     <= seq_d;
			fib_q     <= fib_d;
			tmr_run_q <= tmr_run_d;
			tmr_rem_q <= tmr_rem_d;
		end
	end

endmodule

FILE: rtl/cantr_result_fifo.sv
`timescale 1ns / 1ps

module cantr_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cantr_pkg::step_t   step,
	output logic               room,
	output logic               tvalid,
	input  logic               tready,
	output cantr_pkg::result_t head
);
	import cantr_pkg::*;

	result_t             mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RQ_PTR_W:0]   count_q;
	logic [1:0]          n_push;
	logic                pop;

	assign n_push = push ? step.count : 2'd0;
	assign pop    = tvalid && tready;
	// Space for a full pair is needed before an item is processed.
	assign room   = count_q <= (RQ_PTR_W + 1)'(RQ_DEPTH - 2);
	assign tvalid = count_q != '0;
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < RQ_DEPTH; i++) begin
			if (n_push != 2'd0 && wr_ptr_q == RQ_PTR_W'(i)) begin
				mem_q[i] <= step.first;
			end else if (n_push == 2'd2 && RQ_PTR_W'(wr_ptr_q + 1'b1) == RQ_PTR_W'(i)) begin
				mem_q[i] <= step.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (RQ_PTR_W + 1)'(n_push) - (RQ_PTR_W + 1)'(pop);
		end
	end

endmodule

FILE: rtl/can_transport_receiver_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser op, tdata frame fields
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser kind, tlast last, tdata rest
// cfg       in         cfg_wr_en                      cfg_addr, cfg_wdata
//
// Each frame or tick is registered on entry and then handled by the state update logic,
// which can take a new transaction every cycle while the result queue has room.
// The registered item is handled only while the four-entry result queue has space for two
// results, so items that produce two results each are limited by the one-per-cycle output port.
// Reset clears the phase, counters, timer and queue; block size goes to 0, timeout to 5000.
// A stalled output fills the queue and then holds the input side.

module can_transport_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// byte0..byte6, byte_count, total_length, seq_index, zero fill
	input  logic [79:0] s_axis_tdata,
	// op
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_byte0..out_byte6, out_count, message_end, fc_block_size, zero fill
	output logic [71:0] m_axis_tdata,
	// kind
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import cantr_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    room;
	logic    go;
	step_t   step;
	result_t head;
	cfg_wr_t cfg;

	assign go            = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op           <= s_axis_tuser;
			item_s1.data         <= s_axis_tdata[55:0];
			item_s1.byte_count   <= s_axis_tdata[58:56];
			item_s1.total_length <= s_axis_tdata[70:59];
			item_s1.seq_index    <= s_axis_tdata[74:71];
		end
	end

	assign cfg.en    = cfg_wr_en;
	assign cfg.index = cfg_addr;
	assign cfg.data  = cfg_wdata;

	cantr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.go     (go),
		.item   (item_s1),
		.step   (step)
	);

	cantr_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go),
		.step   (step),
		.room   (room),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.head   (head)
	);

	assign m_axis_tdata = {4'd0, head.fc_block_size, head.message_end, head.out_count,
		head.data};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cantr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// Expected behaviour of the receiver, kept in step with every accepted transaction
	class transport_predictor;
		logic [7:0]  block_size;
		logic [15:0] timeout_ticks;
		logic [1:0]  phase;
		logic [11:0] expected_length;
		logic [11:0] received_count;
		logic [3:0]  seq_ctr;
		logic [7:0]  frames_in_block;
		bit          timer_on;
		logic [15:0] timer_left;
		result_t     pending[$];
		int          errors;
		int          frames;
		int          kind_seen[4];

		function new();
			block_size = 8'd0;
			timeout_ticks = TIMEOUT_RESET;
			phase = PH_IDLE;
			expected_length = '0;
			received_count = '0;
			seq_ctr = '0;
			frames_in_block = '0;
			timer_on = 1'b0;
			timer_left = '0;
			errors = 0;
			frames = 0;
			kind_seen = '{0, 0, 0, 0};
		endfunction

		function void write_register(logic idx, logic [15:0] value);
			if (idx == REG_BLOCK_SIZE) begin
				block_size = value[7:0];
			end else begin
				timeout_ticks = value;
			end
		endfunction

		function void restart_timer();
			timer_on = 1'b1;
			timer_left = timeout_ticks;
		endfunction

		function void stop_timer();
			timer_on = 1'b0;
			timer_left = '0;
		endfunction

		function result_t payload(item_t it, logic [2:0] n, logic done);
			result_t r;
			r = '0;
			r.kind = KIND_PAYLOAD;
			for (int i = 0; i < FRAME_BYTES; i++) begin
				if (i < n) r.data[i] = it.data[i];
			end
			r.out_count = n;
			r.message_end = done;
			return r;
		endfunction

		function result_t flow(logic [1:0] k, logic [7:0] bs);
			result_t r;
			r = '0;
			r.kind = k;
			r.fc_block_size = bs;
			return r;
		endfunction

		function void accept_frame(item_t it);
			result_t     outs[$];
			logic [11:0] rem;
			logic [2:0]  take;
			logic        done;
			if (it.op != OP_TICK) frames++;
			case (it.op)
			OP_SINGLE: begin
				outs.push_back(payload(it, it.byte_count, 1'b1));
				restart_timer();
			end
			OP_FIRST: begin
				if (phase == PH_PROGRESS) begin
					phase = PH_BROKEN;
					outs.push_back(flow(KIND_ABORT, 8'd0));
				end else begin
					take = (it.total_length < 12'(it.byte_count)) ?
						it.total_length[2:0] : it.byte_count;
					stop_timer();
					expected_length = it.total_length;
					received_count = 12'(take);
					seq_ctr = '0;
					frames_in_block = '0;
					if (12'(take) >= it.total_length) begin
						phase = PH_IDLE;
						outs.push_back(payload(it, take, 1'b1));
					end else begin
						phase = PH_PROGRESS;
						outs.push_back(payload(it, take, 1'b0));
						outs.push_back(flow(KIND_CTS, block_size));
						restart_timer();
					end
				end
			end
			OP_CONSEC: begin
				if (phase == PH_PROGRESS) begin
					stop_timer();
					seq_ctr = seq_ctr + 4'd1;
					if (seq_ctr == it.seq_index) begin
						rem = expected_length - received_count;
						take = (rem < 12'(it.byte_count)) ? rem[2:0] : it.byte_count;
						received_count = received_count + 12'(take);
						frames_in_block = frames_in_block + 8'd1;
						done = (received_count == expected_length);
						outs.push_back(payload(it, take, done));
						if (done) begin
							phase = PH_IDLE;
							stop_timer();
						end else if (block_size != 8'd0 && frames_in_block == block_size) begin
							frames_in_block = '0;
							outs.push_back(flow(KIND_CTS, block_size));
							restart_timer();
						end else begin
							restart_timer();
						end
					end else begin
						phase = PH_BROKEN;
						outs.push_back(flow(KIND_ABORT, 8'd0));
					end
				end else if (phase != PH_BROKEN) begin
					phase = PH_BROKEN;
					outs.push_back(flow(KIND_ABORT, 8'd0));
				end
			end
			default: begin
				if (timer_on) begin
					if (timer_left <= 16'd1) begin
						stop_timer();
						outs.push_back(flow(KIND_ABORT, 8'd0));
						outs.push_back(flow(KIND_TIMEOUT, 8'd0));
					end else begin
						timer_left = timer_left - 16'd1;
					end
				end
			end
			endcase
			if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
			foreach (outs[i]) begin
				kind_seen[outs[i].kind]++;
				pending.push_back(outs[i]);
			end
		endfunction

		function void compare(string field, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_delivery(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result of kind %0d arrived with nothing outstanding", got.kind);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("kind", want.kind, got.kind);
			for (int i = 0; i < FRAME_BYTES; i++) begin
				compare($sformatf("out_byte%0d", i), want.data[i], got.data[i]);
			end
			compare("out_count", want.out_count, got.out_count);
			compare("message_end", want.message_end, got.message_end);
			compare("fc_block_size", want.fc_block_size, got.fc_block_size);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// byte0..byte6, byte_count, total_length, seq_index, zero fill
	logic [79:0] s_axis_tdata;
	// op
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// out_byte0..out_byte6, out_count, message_end, fc_block_size, zero fill
	logic [71:0] m_axis_tdata;
	// kind
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_wr_en;
	logic        cfg_addr;
	logic [15:0] cfg_wdata;

	transport_predictor rx_model = new();
	bit quiet = 1'b0;
	int delivered = 0;
	int cycle_count = 0;
	int settings = 0;

	can_transport_receiver_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic item_t random_frame(logic [1:0] op);
		item_t it;
		it.op = op;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			it.data[i] = 8'($urandom_range(0, 255));
		end
		it.byte_count = 3'($urandom_range(0, 7));
		it.total_length = 12'($urandom_range(0, 4095));
		it.seq_index = 4'($urandom_range(0, 15));
		return it;
	endfunction

	// Leaves tvalid high after acceptance; the next call lowers it only for a gap and the drain
	// lowers it, so back-to-back transactions never see two assignments to tvalid in one step.
	task automatic send_frame(input item_t it);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, it.seq_index, it.total_length, it.byte_count, it.data};
		s_axis_tuser <= it.op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		rx_model.accept_frame(it);
	endtask

	task automatic send_op(input logic [1:0] op, input logic [2:0] cnt,
			input logic [11:0] tlen, input logic [3:0] seq);
		item_t it;
		it = random_frame(op);
		it.byte_count = cnt;
		it.total_length = tlen;
		it.seq_index = seq;
		send_frame(it);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_frame(random_frame(OP_TICK));
	endtask

	// A frame that yields no result may still be in the pipeline after the last result.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (rx_model.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] bs, input logic [15:0] ticks);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_addr <= REG_BLOCK_SIZE;
		cfg_wdata <= {8'd0, bs};
		@(posedge clk);
		cfg_addr <= REG_TIMEOUT_TICKS;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rx_model.write_register(REG_BLOCK_SIZE, {8'd0, bs});
		rx_model.write_register(REG_TIMEOUT_TICKS, ticks);
		settings++;
	endtask

	// Mostly well-formed segmented messages with the odd wrong sequence number
	task automatic random_message();
		item_t it;
		int    budget;
		it = random_frame(OP_FIRST);
		if ($urandom_range(0, 19) != 0) it.total_length = 12'($urandom_range(0, 120));
		send_frame(it);
		budget = $urandom_range(1, 40);
		while (rx_model.phase == PH_PROGRESS && budget > 0) begin
			if ($urandom_range(0, 5) == 0) send_ticks(1);
			if ($urandom_range(0, 40) == 0 && rx_model.timeout_ticks <= 16'd8)
				send_ticks(rx_model.timeout_ticks + 1);
			it = random_frame(OP_CONSEC);
			it.seq_index = rx_model.seq_ctr + 4'd1;
			if ($urandom_range(0, 39) == 0) it.seq_index = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 3) != 0) it.byte_count = 3'd7;
			send_frame(it);
			budget--;
		end
	endtask

	task automatic random_traffic(input int n);
		int target;
		int pick;
		target = rx_model.frames + n;
		while (rx_model.frames < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				random_message();
			end else if (pick < 85) begin
				send_frame(random_frame(OP_SINGLE));
				send_ticks($urandom_range(0, 10));
			end else begin
				send_frame(random_frame(2'($urandom_range(0, 3))));
			end
		end
	endtask

	initial begin
		result_t got;
		int      hold;
		bit      long_done;
		hold = 0;
		long_done = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '0;
				got.kind = m_axis_tuser;
				for (int i = 0; i < FRAME_BYTES; i++) got.data[i] = m_axis_tdata[8*i +: 8];
				got.out_count = m_axis_tdata[58:56];
				got.message_end = m_axis_tdata[59];
				got.fc_block_size = m_axis_tdata[67:60];
				got.last = m_axis_tlast;
				rx_model.check_delivery(got);
				delivered++;
			end
			// One long stall lets the result queue fill and push back on the input.
			if (!long_done && delivered >= 150) begin
				hold = 400;
				long_done = 1'b1;
			end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 15);
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		item_t it;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_TICK;
		cfg_wr_en <= 1'b0;
		cfg_addr <= REG_BLOCK_SIZE;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(8'd2, 16'd3);
		send_ticks(1);
		send_op(OP_CONSEC, 3'd7, 12'd0, 4'd1);
		send_op(OP_CONSEC, 3'd7, 12'd0, 4'd1);
		it = random_frame(OP_SINGLE);
		it.data = '1;
		it.byte_count = 3'd7;
		it.total_length = '1;
		it.seq_index = '1;
		send_frame(it);
		send_ticks(3);
		it.data = '0;
		it.byte_count = 3'd0;
		it.total_length = '0;
		it.seq_index = '0;
		send_frame(it);
		send_op(OP_FIRST, 3'd7, 12'd5, 4'd0);
		send_op(OP_FIRST, 3'd0, 12'd0, 4'd0);
		send_op(OP_FIRST, 3'd6, 12'd4095, 4'd0);
		send_op(OP_FIRST, 3'd6, 12'd20, 4'd0);
		send_op(OP_FIRST, 3'd6, 12'd20, 4'd0);
		send_op(OP_CONSEC, 3'd7, 12'd0, 4'd1);
		send_op(OP_CONSEC, 3'd3, 12'd0, 4'd2);
		send_op(OP_CONSEC, 3'd7, 12'd0, 4'd3);
		send_op(OP_FIRST, 3'd6, 12'd30, 4'd0);
		send_op(OP_CONSEC, 3'd7, 12'd0, 4'd5);
		send_op(OP_SINGLE, 3'd4, 12'd0, 4'd0);
		send_ticks(4);

		configure(8'd0, 16'd0);
		random_traffic(160);
		configure(8'd1, 16'd1);
		random_traffic(160);
		configure(8'd255, 16'd65535);
		random_traffic(160);
		configure(8'd3, 16'd4);
		random_traffic(160);
		configure(8'd8, 16'd6);
		quiet = 1'b1;
		random_traffic(160);

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d frames under %0d register settings; checked %0d results:",
			rx_model.frames, settings, delivered);
		$display("  %0d payload, %0d clear-to-send, %0d abort, %0d timeout.",
			rx_model.kind_seen[KIND_PAYLOAD], rx_model.kind_seen[KIND_CTS],
			rx_model.kind_seen[KIND_ABORT], rx_model.kind_seen[KIND_TIMEOUT]);
		if (rx_model.errors == 0 && rx_model.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
